// ----- rtl/core/crfp_pkg.sv -----
`timescale 1ns / 1ps
package crfp_pkg;

  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h56;
  localparam logic [7:0] CMD_MAX = 8'h05;
  localparam logic [5:0] MARKER_LEN = 6'd4;

  typedef enum logic [2:0] {
    PH_HUNT_A   = 3'd0,
    PH_HUNT_B   = 3'd1,
    PH_SEND_ID  = 3'd2,
    PH_COMMAND  = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_MARKER   = 3'd5,
    PH_CHECKSUM = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_BAD_CMD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] frame_send_id;
    logic [7:0] frame_command;
    logic [4:0] payload_offset;
    logic [7:0] payload_value;
    logic       end_marker_ok;
    logic       checksum_ok;
    logic [7:0] frames_seen;
  } result_t;

  function automatic logic [5:0] payload_len(input logic [2:0] cmd);
    logic [5:0] len;
    case (cmd)
      3'd0:    len = 6'd3;
      3'd1:    len = 6'd1;
      3'd2:    len = 6'd5;
      3'd3:    len = 6'd8;
      3'd4:    len = 6'd17;
      3'd5:    len = 6'd17;
      default: len = 6'd3;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] end_marker(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'hCC;
      2'd1:    m = 8'h33;
      2'd2:    m = 8'hC3;
      2'd3:    m = 8'h3C;
      default: m = 8'hCC;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/crfp_deframer.sv -----
`timescale 1ns / 1ps
module crfp_deframer import crfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [4:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] send_id_r, send_id_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic       mgood_r, mgood_nxt;
  logic [7:0] total_r, total_nxt;
  logic [5:0] count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT_A;
      count_r   <= '0;
      xor_r     <= '0;
      send_id_r <= '0;
      cmd_r     <= '0;
      mgood_r   <= 1'b1;
      total_r   <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      xor_r     <= xor_nxt;
      send_id_r <= send_id_nxt;
      cmd_r     <= cmd_nxt;
      mgood_r   <= mgood_nxt;
      total_r   <= total_nxt;
    end
  end

  assign count_inc = {1'b0, count_r} + 6'd1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    send_id_nxt = send_id_r;
    cmd_nxt     = cmd_r;
    mgood_nxt   = mgood_r;
    total_nxt   = total_r;
    res_valid   = 1'b0;
    res.result_kind    = KIND_PAYLOAD;
    res.frame_send_id  = send_id_r;
    res.frame_command  = {5'd0, cmd_r};
    res.payload_offset = '0;
    res.payload_value  = '0;
    res.end_marker_ok  = 1'b0;
    res.checksum_ok    = 1'b0;
    res.frames_seen    = total_r;

    case (phase_r)
      PH_HUNT_B: begin
        if (rx_byte == SYNC_B) begin
          xor_nxt   = SYNC_A ^ SYNC_B;
          mgood_nxt = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_SEND_ID;
        end else begin
          phase_nxt = PH_HUNT_A;
        end
      end
      PH_SEND_ID: begin
        send_id_nxt = rx_byte;
        xor_nxt     = xor_r ^ rx_byte;
        phase_nxt   = PH_COMMAND;
      end
      PH_COMMAND: begin
        xor_nxt = xor_r ^ rx_byte;
        if (rx_byte > CMD_MAX) begin
          res_valid         = 1'b1;
          res.result_kind   = KIND_BAD_CMD;
          res.frame_command = rx_byte;
          phase_nxt         = PH_HUNT_A;
        end else begin
          cmd_nxt   = rx_byte[2:0];
          count_nxt = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xor_nxt            = xor_r ^ rx_byte;
        res_valid          = 1'b1;
        res.result_kind    = KIND_PAYLOAD;
        res.payload_offset = count_r;
        res.payload_value  = rx_byte;
        if (count_inc >= payload_len(cmd_r)) begin
          count_nxt = '0;
          phase_nxt = PH_MARKER;
        end else begin
          count_nxt = count_inc[4:0];
        end
      end
      PH_MARKER: begin
        if (rx_byte != end_marker(count_r[1:0])) mgood_nxt = 1'b0;
        xor_nxt = xor_r ^ rx_byte;
        if (count_inc >= MARKER_LEN) begin
          count_nxt = '0;
          phase_nxt = PH_CHECKSUM;
        end else begin
          count_nxt = count_inc[4:0];
        end
      end
      PH_CHECKSUM: begin
        res_valid         = 1'b1;
        res.result_kind   = KIND_FRAME;
        res.end_marker_ok = mgood_r;
        res.checksum_ok   = (xor_r == rx_byte);
        total_nxt         = total_r + 8'd1;
        count_nxt         = '0;
        phase_nxt         = PH_HUNT_A;
      end
      default: begin
        // hunting first sync byte; unused code lands here too
        phase_nxt = (rx_byte == SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
      end
    endcase
  end

endmodule

// ----- rtl/core/crfp_out_buf.sv -----
`timescale 1ns / 1ps
module crfp_out_buf import crfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop_stall,
  output logic    full,
  output logic    pop_valid,
  output result_t pop_data
);

  // two-entry skid: head in slot 0
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop_data  = slot0_r;
  assign pop       = pop_valid && !pop_stall;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (pop && push) begin
      if (cnt_r == 2'd2) begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end else begin
        slot0_nxt = push_data;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) slot0_nxt = push_data;
      else slot1_nxt = push_data;
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ----- rtl/core/card_reader_frame_parser.sv -----
`timescale 1ns / 1ps
// channel | handshake               | beat payload
// in      | in_valid / in_stall     | in_rx_byte
// out     | out_valid / out_stall   | out_result_kind .. out_frames_seen
//
// One byte per cycle while in_stall is low. The deframer state updates in the
// cycle of the beat; the result is pushed into a two-entry output buffer.
// in_stall rises only when both buffer entries are held by a stalled output.
// Reset (rst_n low, synchronous) returns to hunting the first sync byte and
// empties the buffer; the frame count clears.
module card_reader_frame_parser import crfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_frame_send_id,
  output logic [7:0] out_frame_command,
  output logic [4:0] out_payload_offset,
  output logic [7:0] out_payload_value,
  output logic       out_end_marker_ok,
  output logic       out_checksum_ok,
  output logic [7:0] out_frames_seen
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;

  assign accept = in_valid && !in_stall;

  crfp_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  crfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .pop_stall (out_stall),
    .full      (in_stall),
    .pop_valid (out_valid),
    .pop_data  (head)
  );

  assign out_result_kind    = head.result_kind;
  assign out_frame_send_id  = head.frame_send_id;
  assign out_frame_command  = head.frame_command;
  assign out_payload_offset = head.payload_offset;
  assign out_payload_value  = head.payload_value;
  assign out_end_marker_ok  = head.end_marker_ok;
  assign out_checksum_ok    = head.checksum_ok;
  assign out_frames_seen    = head.frames_seen;

endmodule

// ----- rtl/core/crfp_checker.sv -----
`timescale 1ns / 1ps
module crfp_checker import crfp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_frame_send_id,
  input logic [7:0] out_frame_command,
  input logic [4:0] out_payload_offset,
  input logic [7:0] out_payload_value,
  input logic       out_end_marker_ok,
  input logic       out_checksum_ok,
  input logic [7:0] out_frames_seen
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_frame_send_id) && $stable(out_frame_command)
      && $stable(out_payload_offset) && $stable(out_payload_value)
      && $stable(out_end_marker_ok) && $stable(out_checksum_ok)
      && $stable(out_frames_seen))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input beat changed");

  // flags only on frame results, payload fields only on payload beats
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_FRAME |->
      !out_end_marker_ok && !out_checksum_ok)
    else $error("frame flags on a non-frame beat");

  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_PAYLOAD |->
      out_payload_offset == 5'd0 && out_payload_value == 8'd0)
    else $error("payload fields on a non-payload beat");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("buffer not empty after reset");

endmodule

bind card_reader_frame_parser crfp_checker u_crfp_checker (.*);
